// ===== hw/rtl/fird_pkg.sv =====
// shared constants, codes and types of the fir decimator
`default_nettype none

package fird_pkg;

   localparam int MAX_TAPS    = 1024;
   localparam int TAP_W       = $clog2(MAX_TAPS);
   localparam int CNT_W       = TAP_W + 1;
   localparam int MAX_RATIO   = 64;
   localparam int PHASE_W     = $clog2(MAX_RATIO);
   localparam int RATIO_W     = PHASE_W + 1;
   localparam int SAMPLE_BITS = 16;
   localparam int COEF_BITS   = 18;
   localparam int GAIN_BITS   = 16;
   localparam int PROD_W      = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W       = PROD_W + TAP_W;
   // gain is q1.15, coefficient q0.(COEF_BITS-1)
   localparam int SCALE_SHIFT = COEF_BITS - 1 + 15;
   localparam int SPLIT       = GAIN_BITS;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_DECIM_RATIO = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_COUNT   = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_GAIN    = CSR_IDX_W'(2);

   localparam logic [RATIO_W-1:0]   RATIO_RESET = RATIO_W'(24);
   localparam logic [CNT_W-1:0]     TAPS_RESET  = CNT_W'(745);
   localparam logic [GAIN_BITS-1:0] GAIN_RESET  = GAIN_BITS'(3277);

   // item kinds
   localparam logic REQ_SAMPLE = 1'b0;
   localparam logic REQ_COEF   = 1'b1;

   // marks one read of the tap sweep as it moves down the mac pipeline
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } fird_tag_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          clipped;
   } fird_result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/fird_if.sv =====
// request and response channel interfaces of the fir decimator
`default_nettype none

interface fird_req_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    req_type;
   logic signed [fird_pkg::SAMPLE_BITS-1:0] sample_in;
   logic        [fird_pkg::TAP_W-1:0]       coef_index;
   logic signed [fird_pkg::COEF_BITS-1:0]   coef_value;

   modport source (output valid, output req_type, output sample_in,
                   output coef_index, output coef_value, input ready);
   modport sink   (input valid, input req_type, input sample_in,
                   input coef_index, input coef_value, output ready);
endinterface

interface fird_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [fird_pkg::SAMPLE_BITS-1:0] sample_out;
   logic                                    clipped;

   modport source (output valid, output sample_out, output clipped, input ready);
   modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/fir_decimator.sv =====
// fir decimator top level: control, counters, configuration and output register
`default_nettype none

// streaming fir decimator
// req_if carries items: req_type 0 is a 16-bit sample, req_type 1 writes
// coefficient coef_value (q0.17) at tap coef_index. rsp_if carries one
// result item (sample_out, clipped) per decimated output.
// csr_we/csr_index/csr_wdata write decim_ratio (0), tap_count (1) and
// out_gain (2, q1.15); write only while no item is in flight.
// a sample that produces an output starts a sweep of the taps, one
// multiply-accumulate per cycle through the single read port of each
// memory, then gain and saturation; a coefficient write or a sample that
// produces no output is taken without a sweep.
// the first output comes on sample (tap_count-1)/2, then every decim_ratio
// samples; all coefficients in use must be written before that.
// reset (synchronous) restores the registers and clears the counters, then
// a pass zeroes every entry of the delay line memory, during which
// req_if.ready stays low; configuration writes are taken throughout.
// a result waits in the output register while rsp_if.ready is low; the
// block keeps taking items meanwhile and stalls for the output only when
// the next result is ready and the output register is still full.

module fir_decimator (
   input  wire logic                               clock,
   input  wire logic                               reset,
   fird_req_if.sink                                req_if,
   fird_rsp_if.source                              rsp_if,
   input  wire logic                               csr_we,
   input  wire logic [fird_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [fird_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int TAP_W   = fird_pkg::TAP_W;
   localparam int CNT_W   = fird_pkg::CNT_W;
   localparam int RATIO_W = fird_pkg::RATIO_W;
   localparam int PHASE_W = fird_pkg::PHASE_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ISSUE,
      S_DRAIN,
      S_DELIVER
   } state_type;

   // configuration registers
   logic [RATIO_W-1:0]                ratio_ff;
   logic [CNT_W-1:0]                  taps_ff;
   logic [fird_pkg::GAIN_BITS-1:0]    gain_ff;
   logic [RATIO_W-1:0]                ratio_eff;
   logic [CNT_W-1:0]                  taps_eff;
   logic [CNT_W-1:0]                  half;

   // control state
   state_type                         state_ff, state_in;
   logic [TAP_W-1:0]                  clr_cnt_ff, clr_cnt_in;
   logic [TAP_W-1:0]                  wp_ff, wp_in;
   logic [CNT_W-1:0]                  seen_ff, seen_in;
   logic [PHASE_W-1:0]                phase_ff, phase_in;
   logic [TAP_W-1:0]                  base_ff, base_in;
   logic [CNT_W-1:0]                  cnt_ff, cnt_in;
   fird_pkg::fird_tag_type            tag_ff, tag_in;
   fird_pkg::fird_result_type         res_ff, res_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   fird_pkg::fird_result_type         rsp_data_ff, rsp_data_in;

   logic                              accept;
   logic                              emit;
   logic [RATIO_W-1:0]                phase_inc;

   // memory ports
   logic                                    dly_we;
   logic [TAP_W-1:0]                        dly_waddr;
   logic signed [fird_pkg::SAMPLE_BITS-1:0] dly_wdata;
   logic [TAP_W-1:0]                        dly_raddr;
   logic signed [fird_pkg::SAMPLE_BITS-1:0] dly_rdata;
   logic                                    coef_we;
   logic signed [fird_pkg::COEF_BITS-1:0]   coef_rdata;

   logic signed [fird_pkg::ACC_W-1:0]       mac_acc;
   logic                                    mac_done;
   logic                                    scale_valid;
   fird_pkg::fird_result_type               scale_result;

   // configuration writes, taken in any state
   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff <= fird_pkg::RATIO_RESET;
         taps_ff  <= fird_pkg::TAPS_RESET;
         gain_ff  <= fird_pkg::GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            fird_pkg::CSR_DECIM_RATIO: ratio_ff <= csr_wdata[RATIO_W-1:0];
            fird_pkg::CSR_TAP_COUNT:   taps_ff  <= csr_wdata[CNT_W-1:0];
            fird_pkg::CSR_OUT_GAIN:    gain_ff  <= csr_wdata[fird_pkg::GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // out-of-range settings are clamped
   always_comb begin
      priority if (ratio_ff == '0) begin
         ratio_eff = RATIO_W'(1);
      end else if (ratio_ff > RATIO_W'(fird_pkg::MAX_RATIO)) begin
         ratio_eff = RATIO_W'(fird_pkg::MAX_RATIO);
      end else begin
         ratio_eff = ratio_ff;
      end
      priority if (taps_ff == '0) begin
         taps_eff = CNT_W'(1);
      end else if (taps_ff > CNT_W'(fird_pkg::MAX_TAPS)) begin
         taps_eff = CNT_W'(fird_pkg::MAX_TAPS);
      end else begin
         taps_eff = taps_ff;
      end
   end

   assign half = (taps_eff - CNT_W'(1)) >> 1;

   assign req_if.ready = (state_ff == S_IDLE);
   assign accept       = req_if.valid & (state_ff == S_IDLE);

   // output decision for an accepted sample
   assign phase_inc = RATIO_W'(phase_ff) + RATIO_W'(1);

   always_comb begin
      emit     = 1'b0;
      phase_in = phase_ff;
      if (accept && req_if.req_type == fird_pkg::REQ_SAMPLE) begin
         priority if (seen_ff < half) begin
            phase_in = phase_ff;
         end else if (seen_ff == half) begin
            emit     = 1'b1;
            phase_in = '0;
         end else if (phase_inc >= ratio_eff) begin
            emit     = 1'b1;
            phase_in = '0;
         end else begin
            phase_in = phase_inc[PHASE_W-1:0];
         end
      end
   end

   // delay line writes: zero during the clearing pass, samples afterwards
   always_comb begin
      if (state_ff == S_CLEAR) begin
         dly_we    = 1'b1;
         dly_waddr = clr_cnt_ff;
         dly_wdata = '0;
      end else begin
         dly_we    = accept & (req_if.req_type == fird_pkg::REQ_SAMPLE);
         dly_waddr = wp_ff;
         dly_wdata = req_if.sample_in;
      end
   end

   assign coef_we   = accept & (req_if.req_type == fird_pkg::REQ_COEF);
   // tap m pairs coefficient m with the sample m places back from the newest
   assign dly_raddr = base_ff - cnt_ff[TAP_W-1:0];

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      wp_in        = wp_ff;
      seen_in      = seen_ff;
      base_in      = base_ff;
      cnt_in       = cnt_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_if.ready;
      rsp_data_in  = rsp_data_ff;

      tag_in.valid = (state_ff == S_ISSUE);
      tag_in.first = (cnt_ff == '0);
      tag_in.last  = (cnt_ff == taps_eff - CNT_W'(1));

      unique case (state_ff)
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + TAP_W'(1);
            if (clr_cnt_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept && req_if.req_type == fird_pkg::REQ_SAMPLE) begin
               wp_in = wp_ff + TAP_W'(1);
               if (seen_ff < CNT_W'(fird_pkg::MAX_TAPS)) begin
                  seen_in = seen_ff + CNT_W'(1);
               end
               if (emit) begin
                  base_in  = wp_ff;
                  cnt_in   = '0;
                  state_in = S_ISSUE;
               end
            end
         end
         S_ISSUE: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (tag_in.last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (scale_valid) begin
               res_in   = scale_result;
               state_in = S_DELIVER;
            end
         end
         S_DELIVER: begin
            // wait for the output register to be free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         wp_ff        <= '0;
         seen_ff      <= '0;
         phase_ff     <= '0;
         cnt_ff       <= '0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      base_ff     <= base_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.sample_out = rsp_data_ff.sample_out;
   assign rsp_if.clipped    = rsp_data_ff.clipped;

   fird_mem u_mem (
      .clock      (clock),
      .dly_we     (dly_we),
      .dly_waddr  (dly_waddr),
      .dly_wdata  (dly_wdata),
      .dly_raddr  (dly_raddr),
      .dly_rdata  (dly_rdata),
      .coef_we    (coef_we),
      .coef_waddr (req_if.coef_index),
      .coef_wdata (req_if.coef_value),
      .coef_raddr (cnt_ff[TAP_W-1:0]),
      .coef_rdata (coef_rdata)
   );

   // tag_ff lines up with the registered memory read data
   fird_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .tag_i    (tag_ff),
      .sample_i (dly_rdata),
      .coef_i   (coef_rdata),
      .acc_o    (mac_acc),
      .done_o   (mac_done)
   );

   fird_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .valid_i  (mac_done),
      .acc_i    (mac_acc),
      .gain_i   (gain_ff),
      .valid_o  (scale_valid),
      .result_o (scale_result)
   );

`ifndef SYNTH
   // a finished sum only shows up while control waits for it
   a_mac_done_in_drain: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == S_DRAIN)
      else $error("mac result outside drain");

   a_scale_in_drain: assert property (@(posedge clock) disable iff (reset)
      scale_valid |-> state_ff == S_DRAIN)
      else $error("scaled result outside drain");

   // the sweep never reads past the last tap in use
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ISSUE |-> cnt_ff < taps_eff)
      else $error("tap sweep out of range");

   a_emit_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      emit |=> state_ff == S_ISSUE)
      else $error("output sample did not start a sweep");

   a_seen_saturates: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= CNT_W'(fird_pkg::MAX_TAPS))
      else $error("sample count past saturation");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/fird_mem.sv =====
// delay line and coefficient memories, one write and one registered read each
`default_nettype none

module fird_mem (
   input  wire logic                                    clock,
   input  wire logic                                    dly_we,
   input  wire logic        [fird_pkg::TAP_W-1:0]       dly_waddr,
   input  wire logic signed [fird_pkg::SAMPLE_BITS-1:0] dly_wdata,
   input  wire logic        [fird_pkg::TAP_W-1:0]       dly_raddr,
   output      logic signed [fird_pkg::SAMPLE_BITS-1:0] dly_rdata,
   input  wire logic                                    coef_we,
   input  wire logic        [fird_pkg::TAP_W-1:0]       coef_waddr,
   input  wire logic signed [fird_pkg::COEF_BITS-1:0]   coef_wdata,
   input  wire logic        [fird_pkg::TAP_W-1:0]       coef_raddr,
   output      logic signed [fird_pkg::COEF_BITS-1:0]   coef_rdata
);

   logic signed [fird_pkg::SAMPLE_BITS-1:0] dly_mem  [fird_pkg::MAX_TAPS];
   logic signed [fird_pkg::COEF_BITS-1:0]   coef_mem [fird_pkg::MAX_TAPS];

   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_waddr] <= dly_wdata;
      end
      dly_rdata <= dly_mem[dly_raddr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_waddr] <= coef_wdata;
      end
      coef_rdata <= coef_mem[coef_raddr];
   end

endmodule

`default_nettype wire

// ===== hw/rtl/fird_mac.sv =====
// multiply-accumulate over the tap sweep, one product per cycle
`default_nettype none

module fird_mac (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire fird_pkg::fird_tag_type                  tag_i,
   input  wire logic signed [fird_pkg::SAMPLE_BITS-1:0] sample_i,
   input  wire logic signed [fird_pkg::COEF_BITS-1:0]   coef_i,
   output      logic signed [fird_pkg::ACC_W-1:0]       acc_o,
   output      logic                                    done_o
);

   logic signed [fird_pkg::PROD_W-1:0] prod_ff, prod_in;
   fird_pkg::fird_tag_type             ptag_ff;
   logic signed [fird_pkg::ACC_W-1:0]  acc_ff, acc_in;
   logic                               done_ff;

   assign prod_in = sample_i * coef_i;

   always_comb begin
      acc_in = acc_ff;
      if (ptag_ff.valid) begin
         if (ptag_ff.first) begin
            acc_in = fird_pkg::ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + fird_pkg::ACC_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptag_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ptag_ff <= tag_i;
         done_ff <= ptag_ff.valid & ptag_ff.last;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc_o  = acc_ff;
   assign done_o = done_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/fird_scale.sv =====
// gain, round half up and saturate, two stages
`default_nettype none

module fird_scale (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  valid_i,
   input  wire logic signed [fird_pkg::ACC_W-1:0]     acc_i,
   input  wire logic        [fird_pkg::GAIN_BITS-1:0] gain_i,
   output      logic                                  valid_o,
   output      fird_pkg::fird_result_type             result_o
);

   localparam int Q_W  = fird_pkg::ACC_W - fird_pkg::SPLIT;
   localparam int QG_W = Q_W + fird_pkg::GAIN_BITS + 1;
   localparam int RG_W = fird_pkg::SPLIT + fird_pkg::GAIN_BITS;
   localparam int B_W  = RG_W + 1;
   localparam int T_W  = QG_W + 1;
   localparam int Y_W  = T_W - (fird_pkg::SCALE_SHIFT - fird_pkg::SPLIT);
   localparam int SB   = fird_pkg::SAMPLE_BITS;

   // acc = q * 2^split + r, r unsigned
   logic signed [Q_W-1:0]  q;
   logic        [fird_pkg::SPLIT-1:0] r;
   logic signed [QG_W-1:0] qg_ff, qg_in;
   logic        [RG_W-1:0] rg_ff, rg_in;
   logic                   v1_ff, v2_ff;
   logic        [B_W-1:0]  b;
   logic signed [T_W-1:0]  t;
   logic signed [Y_W-1:0]  y;
   logic                   all_ones, all_zeros;
   fird_pkg::fird_result_type res_ff, res_in;

   assign q     = acc_i[fird_pkg::ACC_W-1:fird_pkg::SPLIT];
   assign r     = acc_i[fird_pkg::SPLIT-1:0];
   assign qg_in = q * $signed({1'b0, gain_i});
   assign rg_in = r * gain_i;

   assign b = {1'b0, rg_ff} + (B_W'(1) << (fird_pkg::SCALE_SHIFT - 1));
   assign t = {qg_ff[QG_W-1], qg_ff} + T_W'(b[B_W-1:fird_pkg::SPLIT]);
   assign y = t[T_W-1:fird_pkg::SCALE_SHIFT-fird_pkg::SPLIT];

   assign all_ones  = &y[Y_W-1:SB-1];
   assign all_zeros = ~|y[Y_W-1:SB-1];

   always_comb begin
      res_in.sample_out = y[SB-1:0];
      res_in.clipped    = 1'b0;
      if (!all_ones && !all_zeros) begin
         res_in.clipped = 1'b1;
         // positive overflow clips to max, negative to min
         res_in.sample_out = y[Y_W-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
      end
      qg_ff  <= qg_in;
      rg_ff  <= rg_in;
      res_ff <= res_in;
   end

   assign valid_o  = v2_ff;
   assign result_o = res_ff;

endmodule

`default_nettype wire

// ===== test/tb_fir_decimator.sv =====
// self-checking testbench of the fir decimator: scoreboard with filter predictor and stimulus
import fird_pkg::*;

class decimator_scoreboard;
   logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
   logic signed [COEF_BITS-1:0]   coefs   [MAX_TAPS];
   logic [TAP_W-1:0]              wr_ptr;
   int unsigned                   seen_count;
   int unsigned                   phase_count;
   logic [RATIO_W-1:0]            ratio_reg;
   logic [CNT_W-1:0]              taps_reg;
   logic [GAIN_BITS-1:0]          gain_reg;
   fird_result_type               pending_outputs [$];
   int                            mismatches;

   function new();
      foreach (history[i]) history[i] = '0;
      foreach (coefs[i]) coefs[i] = '0;
      wr_ptr      = '0;
      seen_count  = 0;
      phase_count = 0;
      ratio_reg   = RATIO_RESET;
      taps_reg    = TAPS_RESET;
      gain_reg    = GAIN_RESET;
      mismatches  = 0;
   endfunction

   function void take_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_DECIM_RATIO: ratio_reg = value[RATIO_W-1:0];
         CSR_TAP_COUNT:   taps_reg  = value[CNT_W-1:0];
         CSR_OUT_GAIN:    gain_reg  = value[GAIN_BITS-1:0];
         default: ;
      endcase
   endfunction

   // one accepted item: update the filter state, queue an output when one is due
   function void take_item(logic kind, logic signed [SAMPLE_BITS-1:0] smp,
                           logic [TAP_W-1:0] idx, logic signed [COEF_BITS-1:0] coef);
      int unsigned     ratio;
      int unsigned     ntaps;
      int unsigned     half;
      int unsigned     m;
      bit              fire;
      longint          acc;
      longint          scaled;
      longint          top;
      logic [TAP_W-1:0] pos;
      fird_result_type res;
      if (kind == REQ_COEF) begin
         coefs[idx] = coef;
         return;
      end
      ratio = (ratio_reg == 0) ? 1 : (ratio_reg > MAX_RATIO) ? MAX_RATIO : ratio_reg;
      ntaps = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
      half  = (ntaps - 1) / 2;
      history[wr_ptr] = smp;
      fire = 1'b0;
      if (seen_count == half) begin
         fire = 1'b1;
         phase_count = 0;
      end else if (seen_count > half) begin
         phase_count++;
         if (phase_count >= ratio) begin
            fire = 1'b1;
            phase_count = 0;
         end
      end
      if (seen_count < MAX_TAPS) seen_count++;
      if (fire) begin
         acc = 0;
         for (m = 0; m < ntaps; m++) begin
            pos = wr_ptr - TAP_W'(m);
            acc += longint'(coefs[m]) * longint'(history[pos]);
         end
         // round half up, then floor, at the q0.17 x q1.15 scale
         scaled = (acc * longint'(gain_reg) + (longint'(1) <<< (SCALE_SHIFT - 1)))
                  >>> SCALE_SHIFT;
         top = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
         res.clipped = 1'b0;
         if (scaled > top) begin
            scaled = top;
            res.clipped = 1'b1;
         end else if (scaled < -top - 1) begin
            scaled = -top - 1;
            res.clipped = 1'b1;
         end
         res.sample_out = scaled[SAMPLE_BITS-1:0];
         pending_outputs.push_back(res);
      end
      wr_ptr = wr_ptr + 1'b1;
   endfunction

   function void check_output(logic signed [SAMPLE_BITS-1:0] got_sample, logic got_clip);
      fird_result_type want;
      if (pending_outputs.size() == 0) begin
         $error("unexpected output: sample_out %0d clipped %0d", got_sample, got_clip);
         mismatches++;
         return;
      end
      want = pending_outputs.pop_front();
      if (got_sample !== want.sample_out) begin
         $error("sample_out: expected %0d, got %0d", want.sample_out, got_sample);
         mismatches++;
      end
      if (got_clip !== want.clipped) begin
         $error("clipped: expected %0d, got %0d", want.clipped, got_clip);
         mismatches++;
      end
   endfunction
endclass

module tb_fir_decimator;
   localparam int HALF_PERIOD   = 6;
   localparam int IDLE_PCT      = 13;
   // longest output is a full 1024-tap sweep plus gain stages
   localparam int SETTLE_CYCLES = MAX_TAPS + 16;
   localparam int HOLD_CYCLES   = 3000;
   // widest filter that any phase below configures
   localparam int TAPS_USED     = 64;
   localparam longint TIMEOUT_TICKS = 64'd36_000_000;
   // index with no register behind it, writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = CSR_IDX_W'(3);

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   bit                    idle_on;
   int                    hold_left;
   decimator_scoreboard   board = new();

   fird_req_if req_bus ();
   fird_rsp_if rsp_bus ();

   fir_decimator uut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_bus),
      .rsp_if    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // output monitor, sampled at the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         board.check_output(rsp_bus.sample_out, rsp_bus.clipped);
      end
   end

   // receiver: random stalls, or a long hold counted here when one is requested
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   initial begin
      #(TIMEOUT_TICKS);
      $display("tb_fir_decimator: FAIL");
      $finish;
   end

   // extremes now and then, small values, otherwise full-range random
   function automatic logic [31:0] pick_word(input int bits);
      case ($urandom_range(7))
         0: return (32'd1 << (bits - 1)) - 32'd1;
         1: return 32'd1 << (bits - 1);
         2, 3: return 32'($urandom_range(64)) - 32'd32;
         default: return $urandom;
      endcase
   endfunction

   // entered and left at a falling edge; valid stays high after acceptance
   task automatic send_item(input logic kind, input logic [SAMPLE_BITS-1:0] smp,
                            input logic [TAP_W-1:0] idx, input logic [COEF_BITS-1:0] coef);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.sample_in  <= smp;
      req_bus.coef_index <= idx;
      req_bus.coef_value <= coef;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.take_item(kind, smp, idx, coef);
      @(negedge clock);
   endtask

   task automatic stream(input int count, input int coef_pct);
      logic kind;
      for (int n = 0; n < count; n++) begin
         kind = ($urandom_range(99) < coef_pct) ? REQ_COEF : REQ_SAMPLE;
         send_item(kind, SAMPLE_BITS'(pick_word(SAMPLE_BITS)), TAP_W'($urandom),
                   COEF_BITS'(pick_word(COEF_BITS)));
      end
   endtask

   // drop valid, wait for every output, then let a full sweep pass
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (board.pending_outputs.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // one register written, the others keep their values
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      board.take_config(idx, value);
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   // write enable held across the burst; the spare index gets random data
   task automatic set_config(input logic [CSR_DATA_W-1:0] ratio,
                             input logic [CSR_DATA_W-1:0] taps,
                             input logic [CSR_DATA_W-1:0] gain);
      logic [CSR_IDX_W-1:0]  idx [4];
      logic [CSR_DATA_W-1:0] val [4];
      idx = '{CSR_DECIM_RATIO, CSR_TAP_COUNT, CSR_OUT_GAIN, CSR_SPARE};
      val = '{ratio, taps, gain, CSR_DATA_W'($urandom)};
      csr_we <= 1'b1;
      foreach (idx[i]) begin
         csr_index <= idx[i];
         csr_wdata <= val[i];
         @(posedge clock);
         board.take_config(idx[i], val[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] ratio,
                            input logic [CSR_DATA_W-1:0] taps,
                            input logic [CSR_DATA_W-1:0] gain,
                            input int count, input int coef_pct);
      settle();
      set_config(ratio, taps, gain);
      stream(count, coef_pct);
   endtask

   initial begin
      logic [SAMPLE_BITS-1:0] directed_samples [12];
      directed_samples = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h8000, 16'h8000,
                           16'h0000, 16'h0001, 16'hffff, 16'h5555, 16'haaaa, 16'h0000};
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = REQ_SAMPLE;
      req_bus.sample_in  = '0;
      req_bus.coef_index = '0;
      req_bus.coef_value = '0;
      idle_on            = 1'b1;
      hold_left          = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every tap in use gets a coefficient before any output can read it;
      // the block waits out its delay line clear on its own
      for (int t = 0; t < TAPS_USED; t++) begin
         send_item(REQ_COEF, SAMPLE_BITS'($urandom), TAP_W'(t),
                   COEF_BITS'(pick_word(COEF_BITS)));
      end

      // short filter, ratio and gain still at their reset values
      settle();
      write_reg(CSR_TAP_COUNT, 16'd33);
      stream(50, 3);

      // directed: unity taps so full-scale runs clip both ways
      settle();
      set_config(16'd1, 16'd5, 16'h8000);
      for (int t = 0; t < 5; t++) begin
         send_item(REQ_COEF, '0, TAP_W'(t), {1'b0, {(COEF_BITS-1){1'b1}}});
      end
      foreach (directed_samples[i]) begin
         send_item(REQ_SAMPLE, directed_samples[i], '0, '0);
      end
      // coefficient extremes: top index and most negative value
      send_item(REQ_COEF, '0, {TAP_W{1'b1}}, {1'b1, {(COEF_BITS-1){1'b0}}});
      send_item(REQ_COEF, '0, '0, {1'b1, {(COEF_BITS-1){1'b0}}});
      send_item(REQ_SAMPLE, 16'h7fff, '0, '0);
      send_item(REQ_SAMPLE, 16'h8000, '0, '0);

      // out-of-range ratio clamps to the maximum
      run_phase(16'd127, 16'd21, CSR_DATA_W'($urandom), 30, 2);
      // ratio lowered below the running phase: output at once
      run_phase(16'd3, 16'd7, 16'd40000, 30, 5);
      run_phase(16'd1, 16'd1, 16'hffff, 20, 5);
      // zero ratio and zero taps act as one, zero gain
      run_phase(16'd0, 16'd0, 16'd0, 20, 5);
      // even tap count
      run_phase(16'd2, 16'd4, CSR_DATA_W'($urandom), 30, 10);

      // output held off long enough for the block to stall its input
      settle();
      set_config(16'd1, 16'd9, 16'h8000);
      hold_left = HOLD_CYCLES;
      stream(40, 0);

      // no idling on either side
      settle();
      set_config(16'd5, 16'd33, 16'd16384);
      idle_on = 1'b0;
      stream(40, 5);
      settle();
      idle_on = 1'b1;

      // stray upper bits are dropped by the register widths
      run_phase(16'h0181, 16'hf80b, CSR_DATA_W'($urandom), 20, 5);
      repeat (2) begin
         run_phase(CSR_DATA_W'($urandom_range(8, 1)),
                   CSR_DATA_W'($urandom_range(TAPS_USED, 1)),
                   CSR_DATA_W'($urandom), 25, 8);
      end

      settle();
      if (board.mismatches == 0 && board.pending_outputs.size() == 0) begin
         $display("tb_fir_decimator: PASS");
      end else begin
         $display("tb_fir_decimator: FAIL");
      end
      $finish;
   end
endmodule
